// ===== design/fnt_pkg.sv =====
// Shared types and constants for the forbidden network table.
package fnt_pkg;

    localparam int TABLE_DEPTH = 16;

    localparam int CODE_W   = 10;
    localparam int CAUSE_W  = 8;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_DEL   = 2'd1,
        ACT_QUERY = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_HOME      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CARD_PRESENT = 2'd0,
        REG_HOME_COUNTRY = 2'd1,
        REG_HOME_NETWORK = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CODE_W-1:0]   country_code;
        logic [CODE_W-1:0]   network_code;
        logic [CAUSE_W-1:0]  reject_cause;
    } request_t;

    typedef struct packed {
        logic               card_present;
        logic [CODE_W-1:0]  home_country_code;
        logic [CODE_W-1:0]  home_network_code;
    } cfg_t;

    typedef struct packed {
        status_t            status;
        logic               is_forbidden;
        logic [CAUSE_W-1:0] matched_cause;
    } result_t;

endpackage

// ===== design/fnt_table.sv =====
// Slot store with parallel match, lowest-slot select and add/delete update.
module fnt_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  fnt_pkg::cfg_t     cfg,
    input  fnt_pkg::request_t req,
    output fnt_pkg::result_t  res
);
    import fnt_pkg::*;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [TABLE_DEPTH-1:0] valid_next;
    logic [CODE_W-1:0]      country_reg [TABLE_DEPTH];
    logic [CODE_W-1:0]      network_reg [TABLE_DEPTH];
    logic [CAUSE_W-1:0]     cause_reg   [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] match_vec;
    logic [TABLE_DEPTH-1:0] free_vec;
    logic [TABLE_DEPTH-1:0] match_hot;
    logic [TABLE_DEPTH-1:0] free_hot;
    logic [TABLE_DEPTH-1:0] write_hot;
    logic [CAUSE_W-1:0]     hit_cause;
    logic                   home_hit;

    always_comb
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            match_vec[i] = valid_reg[i]
                           && (country_reg[i] == req.country_code)
                           && (network_reg[i] == req.network_code);
        end
    end

    assign free_vec  = ~valid_reg;
    // isolate lowest set bit
    assign match_hot = match_vec & (~match_vec + TABLE_DEPTH'(1));
    assign free_hot  = free_vec & (~free_vec + TABLE_DEPTH'(1));

    always_comb
    begin
        hit_cause = '0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            hit_cause = hit_cause | ({CAUSE_W{match_hot[i]}} & cause_reg[i]);
        end
    end

    assign home_hit = cfg.card_present
                      && (req.country_code == cfg.home_country_code)
                      && (req.network_code == cfg.home_network_code);

    always_comb
    begin
        res        = '{status: ST_OK, is_forbidden: 1'b0, matched_cause: '0};
        valid_next = valid_reg;
        write_hot  = '0;
        case (req.action)
            ACT_ADD:
            begin
                if (home_hit)
                begin
                    res.status = ST_HOME;
                end
                else if (free_vec == '0)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    write_hot  = free_hot;
                    valid_next = valid_reg | free_hot;
                end
            end
            ACT_DEL:
            begin
                if (match_vec == '0)
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    valid_next = valid_reg & ~match_hot;
                end
            end
            ACT_QUERY:
            begin
                res.is_forbidden  = |match_vec;
                res.matched_cause = hit_cause;
            end
            default:
            begin
                res = '{status: ST_OK, is_forbidden: 1'b0, matched_cause: '0};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (en && write_hot[i])
            begin
                country_reg[i] <= req.country_code;
                network_reg[i] <= req.network_code;
                cause_reg[i]   <= req.reject_cause;
            end
        end
    end

endmodule

// ===== design/forbidden_network_table_top.sv =====
// Top level of the forbidden network table: stream ports, registers, staging.
// Staging: input register, then table lookup and update into the result register.
// Throughput: 1 request per cycle unless m_tready stalls a held result; each request sees the table
//   updates of the one before.
// Reset: rst_n clears the valid flags of all slots, the configuration registers
//   and both stage valids; slot contents are left as they are.
module forbidden_network_table_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] action, [11:2] country_code, [21:12] network_code,
    // [29:22] reject_cause, [31:30] zero
    input  logic [fnt_pkg::IN_DATA_W-1:0]       s_tdata,
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] status, [2] is_forbidden, [10:3] matched_cause, [15:11] zero
    output logic [fnt_pkg::OUT_DATA_W-1:0]      m_tdata,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [fnt_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fnt_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import fnt_pkg::*;

    // Configuration registers
    cfg_t     cfg_reg;

    // Input stage: holds one request until the result register can take it
    logic     in_valid_reg;
    request_t in_req_reg;

    // Result stage
    logic     out_valid_reg;
    result_t  out_res_reg;

    result_t  lookup_res;
    logic     advance;

    // Move the staged request into the result register when that register
    // is empty or is being drained this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CARD_PRESENT: cfg_reg.card_present      <= cfg_data[0];
                REG_HOME_COUNTRY: cfg_reg.home_country_code <= cfg_data[CODE_W-1:0];
                REG_HOME_NETWORK: cfg_reg.home_network_code <= cfg_data[CODE_W-1:0];
                default:          cfg_reg <= cfg_reg; // drop writes beyond the list
            endcase
        end
    end

    // Input register: valid cleared under reset, payload loaded on every accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg.action       <= s_tdata[1:0];
            in_req_reg.country_code <= s_tdata[11:2];
            in_req_reg.network_code <= s_tdata[21:12];
            in_req_reg.reject_cause <= s_tdata[29:22];
        end
    end

    // Table lookup and update; state advances only with the request
    fnt_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (advance),
        .cfg   (cfg_reg),
        .req   (in_req_reg),
        .res   (lookup_res)
    );

    // Result register: hold until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= lookup_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.matched_cause, out_res_reg.is_forbidden,
                       out_res_reg.status};

endmodule
